// ===== hw/rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the streaming find and replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int MAX_RUN         = 8;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 4;
    localparam int RUN_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 8;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 8'd3;

    typedef struct packed {
        logic [MAX_RUN-1:0][BYTE_W-1:0] bytes;
        logic [LEN_W-1:0]               count;
        logic                           present;
        logic                           eos;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== hw/rtl/stream_find_replace.sv =====
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming substring find and replace with a pattern and a replacement of
// up to eight bytes each.
// ----------------------------------------------------------------------------
// An accepted input word is written into the job queue; its first result is then
// loaded from the queue head into the output register.
// Throughput: one input word per cycle while each yields at most one result and the
// output is not stalled. A word with more than one result holds the output stage
// until all are sent; the four-entry job queue absorbs bursts before input stalls.
// Reset clears the configuration to zero, empties the window and the queue.
module stream_find_replace
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sfr_pkg::BYTE_W-1:0]      data_byte,
    input  logic                            end_of_stream,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sfr_pkg::BYTE_W-1:0]      out_byte,
    output logic                            byte_present,
    output logic                            last_of_run,
    output logic                            stream_done
);

    sfr_pkg::queue_status_t q_status;
    sfr_pkg::job_t          push_job;
    sfr_pkg::job_t          head_job;
    logic                   push;
    logic                   pop;

    sfr_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .q_status      (q_status),
        .push          (push),
        .push_job      (push_job)
    );

    sfr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    sfr_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_job     (head_job),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .byte_present (byte_present),
        .last_of_run  (last_of_run),
        .stream_done  (stream_done)
    );

endmodule

// ===== hw/rtl/sfr_front.sv =====
// ----------------------------------------------------------------------------
// sfr_front
// Holds the configuration and the pending window, matches each incoming
// byte and turns it into a job of up to eight output bytes for the back end.
// ----------------------------------------------------------------------------
module sfr_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [sfr_pkg::BYTE_W-1:0]            data_byte,
    input  logic                                  end_of_stream,
    input  sfr_pkg::queue_status_t                q_status,
    output logic                                  push,
    output sfr_pkg::job_t                         push_job
);

    logic [sfr_pkg::CFG_DATA_W-1:0] pattern_reg, pattern_next;
    logic [sfr_pkg::CFG_DATA_W-1:0] repl_reg, repl_next;
    logic [sfr_pkg::LEN_W-1:0]      plen_cfg_reg, plen_cfg_next;
    logic [sfr_pkg::LEN_W-1:0]      rlen_cfg_reg, rlen_cfg_next;
    logic [sfr_pkg::LEN_W-1:0]      pcount_reg, pcount_next;
    logic [sfr_pkg::MAX_PATTERN-1:0][sfr_pkg::BYTE_W-1:0] window_reg, window_next;

    logic [sfr_pkg::MAX_PATTERN-1:0][sfr_pkg::BYTE_W-1:0] new_win;
    logic [sfr_pkg::MAX_PATTERN-1:0][sfr_pkg::BYTE_W-1:0] shift_win;
    logic [sfr_pkg::LEN_W-1:0] plen;
    logic [sfr_pkg::LEN_W-1:0] rlen;
    logic [sfr_pkg::LEN_W-1:0] pc_eff;
    logic [sfr_pkg::LEN_W-1:0] pc_inc;
    logic                      full;
    logic                      match;
    logic                      accept;
    sfr_pkg::job_t             job;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_status.full;
    assign accept    = in_valid && !q_status.full;

    assign plen = (plen_cfg_reg > sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN)) ?
                  sfr_pkg::LEN_W'(sfr_pkg::MAX_PATTERN) : plen_cfg_reg;
    assign rlen = (rlen_cfg_reg > sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACEMENT)) ?
                  sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACEMENT) : rlen_cfg_reg;
    assign pc_eff = (pcount_reg >= plen) ? '0 : pcount_reg;
    assign pc_inc = pc_eff + sfr_pkg::LEN_W'(1);
    assign full   = (pc_inc == plen);

    always_comb
    begin
        for (int i = 0; i < sfr_pkg::MAX_PATTERN; i++)
        begin
            new_win[i] = (sfr_pkg::RUN_IDX_W'(i) == pc_eff[sfr_pkg::RUN_IDX_W-1:0]) ?
                         data_byte : window_reg[i];
        end
        for (int i = 0; i < sfr_pkg::MAX_PATTERN; i++)
        begin
            if (i < sfr_pkg::MAX_PATTERN - 1)
                shift_win[i] = new_win[(i + 1) % sfr_pkg::MAX_PATTERN];
            else
                shift_win[i] = new_win[i];
        end
        match = 1'b1;
        for (int i = 0; i < sfr_pkg::MAX_PATTERN; i++)
        begin
            if ((sfr_pkg::LEN_W'(i) < plen) &&
                (new_win[i] != pattern_reg[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]))
                match = 1'b0;
        end
    end

    always_comb
    begin
        job         = '0;
        job.present = 1'b1;
        job.eos     = end_of_stream;
        window_next = window_reg;
        pcount_next = pcount_reg;
        if (plen == '0)
        begin
            job.bytes[0] = data_byte;
            job.count    = sfr_pkg::LEN_W'(1);
            pcount_next  = '0;
        end
        else if (full && match)
        begin
            job.bytes   = repl_reg;
            job.count   = rlen;
            window_next = new_win;
            pcount_next = '0;
        end
        else
        begin
            job.bytes = new_win;
            if (end_of_stream)
                job.count = pc_inc;
            else if (full)
                job.count = sfr_pkg::LEN_W'(1);
            else
                job.count = '0;
            window_next = full ? shift_win : new_win;
            pcount_next = full ? pc_eff : pc_inc;
            if (end_of_stream)
                pcount_next = '0;
        end
        if (end_of_stream && job.count == '0)
        begin
            job.count   = sfr_pkg::LEN_W'(1);
            job.present = 1'b0;
            job.bytes   = '0;
        end
    end

    assign push     = accept && (job.count != '0);
    assign push_job = job;

    always_comb
    begin
        pattern_next  = pattern_reg;
        repl_next     = repl_reg;
        plen_cfg_next = plen_cfg_reg;
        rlen_cfg_next = rlen_cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                sfr_pkg::REG_PATTERN_BYTES:      pattern_next  = cfg_data;
                sfr_pkg::REG_PATTERN_LENGTH:     plen_cfg_next = cfg_data[sfr_pkg::LEN_W-1:0];
                sfr_pkg::REG_REPLACEMENT_BYTES:  repl_next     = cfg_data;
                sfr_pkg::REG_REPLACEMENT_LENGTH: rlen_cfg_next = cfg_data[sfr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg  <= '0;
            repl_reg     <= '0;
            plen_cfg_reg <= '0;
            rlen_cfg_reg <= '0;
            pcount_reg   <= '0;
        end
        else
        begin
            pattern_reg  <= pattern_next;
            repl_reg     <= repl_next;
            plen_cfg_reg <= plen_cfg_next;
            rlen_cfg_reg <= rlen_cfg_next;
            if (cfg_valid && cfg_index == sfr_pkg::REG_PATTERN_LENGTH)
                pcount_reg <= '0;
            else if (accept)
                pcount_reg <= pcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            window_reg <= window_next;
    end

endmodule

// ===== hw/rtl/sfr_queue.sv =====
// ----------------------------------------------------------------------------
// sfr_queue
// Short job queue that decouples the matching front end from the output
// back end.
// ----------------------------------------------------------------------------
module sfr_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  sfr_pkg::job_t          push_job,
    input  logic                   pop,
    output sfr_pkg::job_t          head_job,
    output sfr_pkg::queue_status_t status
);

    sfr_pkg::job_t entries_reg [sfr_pkg::QUEUE_DEPTH];
    logic [sfr_pkg::QPTR_W-1:0] wptr_reg, wptr_next;
    logic [sfr_pkg::QPTR_W-1:0] rptr_reg, rptr_next;
    logic [sfr_pkg::QPTR_W:0]   fill_reg, fill_next;

    assign status.full  = (fill_reg == (sfr_pkg::QPTR_W+1)'(sfr_pkg::QUEUE_DEPTH));
    assign status.empty = (fill_reg == '0);
    assign head_job     = entries_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + sfr_pkg::QPTR_W'(1) : wptr_reg;
        rptr_next = pop ? rptr_reg + sfr_pkg::QPTR_W'(1) : rptr_reg;
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + (sfr_pkg::QPTR_W+1)'(1);
        else if (pop && !push)
            fill_next = fill_reg - (sfr_pkg::QPTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wptr_reg] <= push_job;
    end

endmodule

// ===== hw/rtl/sfr_back.sv =====
// ----------------------------------------------------------------------------
// sfr_back
// Walks through the job at the head of the queue and sends one output word per
// cycle to the output register unless the queue is empty or out_stall holds it.
// ----------------------------------------------------------------------------
module sfr_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  sfr_pkg::job_t              head_job,
    input  sfr_pkg::queue_status_t     q_status,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [sfr_pkg::BYTE_W-1:0] out_byte,
    output logic                       byte_present,
    output logic                       last_of_run,
    output logic                       stream_done
);

    logic [sfr_pkg::RUN_IDX_W-1:0] idx_reg, idx_next;
    logic                          valid_reg, valid_next;
    logic [sfr_pkg::BYTE_W-1:0]    byte_reg;
    logic                          present_reg;
    logic                          last_reg;
    logic                          done_reg;
    logic                          load;
    logic                          is_last;

    assign load    = !q_status.empty && (!valid_reg || !out_stall);
    assign is_last = ({1'b0, idx_reg} == head_job.count - sfr_pkg::LEN_W'(1));
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
            idx_next = is_last ? '0 : idx_reg + sfr_pkg::RUN_IDX_W'(1);
        if (load)
            valid_next = 1'b1;
        else
            valid_next = valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= head_job.bytes[idx_reg];
            present_reg <= head_job.present;
            last_reg    <= is_last;
            done_reg    <= is_last && head_job.eos;
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign byte_present = present_reg;
    assign last_of_run  = last_reg;
    assign stream_done  = done_reg;

endmodule
